### hw/rtl/tilt_posture_alarm_core_macros.svh
// Assertion macros used by the tilt posture alarm sequencer.
`ifndef TILT_POSTURE_ALARM_CORE_MACROS_SVH
`define TILT_POSTURE_ALARM_CORE_MACROS_SVH
`ifndef SYNTH
`define TPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TPA_ASSERT(lbl, prop, msg)
`define TPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hw/rtl/tpa_pkg.sv
// Shared types, constants and the arctangent table of the tilt posture alarm.
`timescale 1ns / 1ps
package tpa_pkg;
  localparam int CORDIC_ITERS = 16;
  localparam int ROOT_STEPS   = 17;
  localparam int ITER_W       = 5;
  localparam int CW           = 27;
  localparam int ZW           = 25;
  localparam int AW           = 17;
  localparam logic signed [AW-1:0] ANGLE_MAX = 17'sd23040;

  localparam logic [1:0] REG_RED_LIMIT    = 2'd0;
  localparam logic [1:0] REG_YELLOW_LIMIT = 2'd1;
  localparam logic [1:0] REG_NOTIFY_DELAY = 2'd2;
  localparam logic [1:0] REG_PING_INTVL   = 2'd3;

  typedef enum logic [1:0] {MUL_PITCH, MUL_ROLL, MUL_DEV} mul_sel_e;

  typedef struct packed {
    logic              load;
    logic              mul_first;
    logic              mul_next;
    mul_sel_e          mul_sel;
    logic              root_init;
    logic              root_step;
    logic              cord_init;
    logic              cord_step;
    logic              ang_store;
    logic              pass;
    logic              diff;
    logic              cal_store;
    logic              finish;
    logic [ITER_W-1:0] iter;
  } tpa_cmd_t;

  typedef struct packed {
    logic is_cal;
  } tpa_stat_t;

  // Arctangent of 2^-i in Q16 degrees.
  function automatic logic signed [ZW-1:0] atan_tab(input logic [ITER_W-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      5'd20: v = 25'sd4;
      5'd21: v = 25'sd2;
      5'd22: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction
endpackage

### hw/rtl/tilt_posture_alarm_core.sv
// Top level of the accelerometer tilt posture alarm.
`timescale 1ns / 1ps
// Each sample word yields pitch and roll by a 16-step CORDIC, corrected by the
// calibrated offsets, their floor-root magnitude as deviation, the red and yellow
// flags, and the alert and ping timer events; a calibrate word (tuser high)
// takes new offsets from the last sample and returns no word. One shared
// squarer, a bit-serial square root and the CORDIC unit are stepped by the
// sequencer; a new word is taken once the previous one has left the
// datapath, while a finished result may still wait in the output register.
module tilt_posture_alarm_core import tpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // accel_x, accel_y, accel_z, now_ms
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // tilt_x, tilt_y, deviation, is_red,
                                     // is_yellow, alert, ping, zero pad
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  tpa_cmd_t    cmd;
  tpa_stat_t   stat;
  logic [53:0] out_data;

  tpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tpa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_cmd_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_data_o (out_data)
  );

  assign m_axis_tdata = {2'b00, out_data};
endmodule

### hw/rtl/tpa_ctrl.sv
// Sequencer that steps the tilt datapath through angles, root and alarm update.
`timescale 1ns / 1ps
`include "tilt_posture_alarm_core_macros.svh"
module tpa_ctrl import tpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  tpa_stat_t stat_i,
  output tpa_cmd_t  cmd_o
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL0   = 4'd1;
  localparam logic [3:0] S_MUL1   = 4'd2;
  localparam logic [3:0] S_RINIT  = 4'd3;
  localparam logic [3:0] S_ROOT   = 4'd4;
  localparam logic [3:0] S_CINIT  = 4'd5;
  localparam logic [3:0] S_CORD   = 4'd6;
  localparam logic [3:0] S_ANG    = 4'd7;
  localparam logic [3:0] S_DIFF   = 4'd8;
  localparam logic [3:0] S_DMUL0  = 4'd9;
  localparam logic [3:0] S_DMUL1  = 4'd10;
  localparam logic [3:0] S_DRINIT = 4'd11;
  localparam logic [3:0] S_DROOT  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]        state_q, state_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic              pass_q, pass_d;
  logic              oval_q, oval_d;
  logic              out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = oval_q;
  assign out_free    = !oval_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pass_d  = pass_q;
    oval_d  = oval_q && !out_ready_i;
    cmd_o   = '0;
    cmd_o.pass    = pass_q;
    cmd_o.iter    = cnt_q;
    cmd_o.mul_sel = pass_q ? MUL_ROLL : MUL_PITCH;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pass_d     = 1'b0;
          state_d    = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_first = 1'b1;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_next = 1'b1;
        state_d = S_RINIT;
      end
      S_RINIT: begin
        cmd_o.root_init = 1'b1;
        cnt_d   = '0;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ITER_W'(ROOT_STEPS - 1)) begin
          state_d = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd_o.cord_init = 1'b1;
        cnt_d   = '0;
        state_d = S_CORD;
      end
      S_CORD: begin
        cmd_o.cord_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ITER_W'(CORDIC_ITERS - 1)) begin
          state_d = S_ANG;
        end
      end
      S_ANG: begin
        cmd_o.ang_store = 1'b1;
        if (!pass_q) begin
          pass_d  = 1'b1;
          state_d = S_MUL0;
        end else begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        if (stat_i.is_cal) begin
          cmd_o.cal_store = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.diff = 1'b1;
          state_d = S_DMUL0;
        end
      end
      S_DMUL0: begin
        cmd_o.mul_sel   = MUL_DEV;
        cmd_o.mul_first = 1'b1;
        state_d = S_DMUL1;
      end
      S_DMUL1: begin
        cmd_o.mul_sel  = MUL_DEV;
        cmd_o.mul_next = 1'b1;
        state_d = S_DRINIT;
      end
      S_DRINIT: begin
        cmd_o.root_init = 1'b1;
        cnt_d   = '0;
        state_d = S_DROOT;
      end
      S_DROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ITER_W'(ROOT_STEPS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          oval_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
      oval_q  <= oval_d;
    end
  end

  `TPA_ASSERT(a_word_from_done, $rose(oval_q) |-> $past(state_q) == S_DONE, "result word not from final state")
  `TPA_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> state_q != S_IDLE, "accepted word dropped")
  `TPA_ASSERT(a_cnt_bound, cnt_q <= ITER_W'(ROOT_STEPS > CORDIC_ITERS ? ROOT_STEPS : CORDIC_ITERS), "step counter overran")
  `TPA_ASSERT(a_hold_word, (oval_q && !out_ready_i) |=> oval_q, "result word lost while stalled")
endmodule

### hw/rtl/tpa_dp.sv
// Datapath: squarer, bit-serial square root, CORDIC angle unit and alarm timers.
`timescale 1ns / 1ps
module tpa_dp import tpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tpa_cmd_t    cmd_i,
  output tpa_stat_t   stat_o,
  input  logic        in_cmd_i,
  input  logic [79:0] in_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic [53:0] out_data_o
);
  logic [15:0] red_q, yellow_q, notify_q, ping_iv_q;
  logic signed [15:0] opx_q, opy_q, opz_q, last_x_q, last_y_q, last_z_q;
  logic        is_cal_q;
  logic [31:0] now_q;
  logic [33:0] acc_q, rv_q;
  logic [18:0] rem_q;
  logic [16:0] root_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] cz_q;
  logic signed [AW-1:0] pitch_q, roll_q, offp_q, offr_q, tx_q, ty_q;
  logic        in_bad_q;
  logic [31:0] bad_start_q, ping_start_q;
  logic [53:0] out_q;

  assign stat_o.is_cal = is_cal_q;
  assign out_data_o    = out_q;

  // Squarer operand and accumulated sum of squares.
  logic signed [AW-1:0]   mul_a;
  logic signed [2*AW-1:0] prod;
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_PITCH: mul_a = cmd_i.mul_next ? AW'(opz_q) : AW'(opy_q);
      MUL_ROLL:  mul_a = cmd_i.mul_next ? AW'(opz_q) : AW'(opx_q);
      MUL_DEV:   mul_a = cmd_i.mul_next ? ty_q : tx_q;
      default:   mul_a = '0;
    endcase
    prod = mul_a * mul_a;
  end

  // One result bit of the floor square root per step.
  logic [20:0] rem_w, trial;
  logic        take;
  always_comb begin
    rem_w = {rem_q, rv_q[33:32]};
    trial = {2'b00, root_q, 2'b01};
    take  = (rem_w >= trial);
  end

  // CORDIC vectoring step.
  logic signed [15:0]   ang_a;
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] zr, zs;
  logic signed [AW-1:0] ang, clamp;
  always_comb begin
    ang_a = cmd_i.pass ? opy_q : opx_q;
    dx    = cy_q >>> cmd_i.iter;
    dy    = cx_q >>> cmd_i.iter;
    zr    = cz_q + ZW'(128);
    zs    = zr >>> 8;
    if (zs > ZW'(ANGLE_MAX)) begin
      clamp = ANGLE_MAX;
    end else if (zs < -ZW'(ANGLE_MAX)) begin
      clamp = -ANGLE_MAX;
    end else begin
      clamp = zs[AW-1:0];
    end
    priority if (ang_a == 16'sd0) begin
      ang = '0;
    end else if (root_q == '0) begin
      ang = ang_a[15] ? -ANGLE_MAX : ANGLE_MAX;
    end else begin
      ang = clamp;
    end
  end

  // Deviation compare and the dwell and ping timers.
  logic [15:0] dev;
  logic        red, yellow, alert, ping_hit;
  logic [31:0] bs, notify_ms, ping_ms;
  always_comb begin
    dev       = root_q[16] ? 16'hFFFF : root_q[15:0];
    red       = dev > red_q;
    yellow    = dev > yellow_q;
    notify_ms = 32'(notify_q) * 32'd1000;
    ping_ms   = 32'(ping_iv_q) * 32'd1000;
    bs        = in_bad_q ? bad_start_q : now_q;
    alert     = red && ((now_q - bs) >= notify_ms) && (notify_q != '0);
    ping_hit  = (now_q - ping_start_q) >= ping_ms;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q        <= 16'd3840;
      yellow_q     <= 16'd1280;
      notify_q     <= 16'd60;
      ping_iv_q    <= 16'd10;
      last_x_q     <= '0;
      last_y_q     <= '0;
      last_z_q     <= '0;
      offp_q       <= '0;
      offr_q       <= '0;
      in_bad_q     <= 1'b0;
      bad_start_q  <= '0;
      ping_start_q <= '0;
      is_cal_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RED_LIMIT:    red_q     <= cfg_wdata_i;
          REG_YELLOW_LIMIT: yellow_q  <= cfg_wdata_i;
          REG_NOTIFY_DELAY: notify_q  <= cfg_wdata_i;
          REG_PING_INTVL:   ping_iv_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        is_cal_q <= in_cmd_i;
        if (in_cmd_i) begin
          last_x_q <= '0;
          last_y_q <= '0;
        end else begin
          last_x_q <= in_data_i[15:0];
          last_y_q <= in_data_i[31:16];
          last_z_q <= in_data_i[47:32];
        end
      end
      if (cmd_i.cal_store) begin
        offp_q <= pitch_q;
        offr_q <= roll_q;
      end
      if (cmd_i.finish) begin
        if (red) begin
          in_bad_q    <= 1'b1;
          bad_start_q <= ((now_q - bs) >= notify_ms) ? now_q : bs;
        end else begin
          in_bad_q <= 1'b0;
        end
        if (ping_hit) begin
          ping_start_q <= now_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q <= in_data_i[79:48];
      if (in_cmd_i) begin
        opx_q <= last_x_q;
        opy_q <= last_y_q;
        opz_q <= last_z_q;
      end else begin
        opx_q <= in_data_i[15:0];
        opy_q <= in_data_i[31:16];
        opz_q <= in_data_i[47:32];
      end
    end
    if (cmd_i.mul_first) begin
      acc_q <= prod;
    end else if (cmd_i.mul_next) begin
      acc_q <= acc_q + prod;
    end
    if (cmd_i.root_init) begin
      rv_q   <= acc_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rv_q   <= {rv_q[31:0], 2'b00};
      rem_q  <= take ? 19'(rem_w - trial) : rem_w[18:0];
      root_q <= {root_q[15:0], take};
    end
    if (cmd_i.cord_init) begin
      cx_q <= {2'b00, root_q, 8'h00};
      cy_q <= {{3{ang_a[15]}}, ang_a, 8'h00};
      cz_q <= '0;
    end else if (cmd_i.cord_step) begin
      if (cy_q > 0) begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + atan_tab(cmd_i.iter);
      end else begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - atan_tab(cmd_i.iter);
      end
    end
    if (cmd_i.ang_store) begin
      if (cmd_i.pass) begin
        roll_q <= -ang;
      end else begin
        pitch_q <= ang;
      end
    end
    if (cmd_i.diff) begin
      tx_q <= pitch_q - offp_q;
      ty_q <= roll_q - offr_q;
    end
    if (cmd_i.finish) begin
      out_q <= {ping_hit, alert, yellow, red, dev, ty_q, tx_q};
    end
  end
endmodule
